>>> rtl/sare_pkg.sv
// ----------------------------------------------------------------------------
// sare_pkg
// Types, constants and helpers shared by the smoothed activity run-length
// encoder.
// ----------------------------------------------------------------------------
package sare_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int SAMPLE_WIDTH = 16;
	localparam int LIMIT_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH = 32;
	localparam int CMP_WIDTH = (COUNT_WIDTH > LIMIT_WIDTH) ? COUNT_WIDTH : LIMIT_WIDTH;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SILENCE_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SMOOTHING = 2'd2;

	typedef enum logic [1:0] {
		KIND_START  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_ADD    = 2'd2
	} record_kind_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] threshold;
		logic [LIMIT_WIDTH-1:0]         silence_limit;
		logic                           smoothing;
	} cfg_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample;
		logic                           stream_start;
	} item_t;

	typedef struct packed {
		logic                   emit;
		record_kind_t           kind;
		logic [VALUE_WIDTH-1:0] value;
	} rec_t;

	function automatic logic [VALUE_WIDTH-1:0] clip_value(input logic [COUNT_WIDTH-1:0] cnt);
		logic [CMP_WIDTH-1:0] wide;
		logic [VALUE_WIDTH-1:0] res;
		wide = CMP_WIDTH'(cnt);
		if ((wide >> VALUE_WIDTH) != '0) begin
			res = {VALUE_WIDTH{1'b1}};
		end else begin
			res = wide[VALUE_WIDTH-1:0];
		end
		return res;
	endfunction

endpackage

>>> rtl/smoothed_activity_run_length_encoder_top.sv
// ----------------------------------------------------------------------------
// smoothed_activity_run_length_encoder_top
// Threshold activity detector with run-length records and optional merging
// of short silences.
// Each accepted beat is registered in item_s1, its record (if any) in rec_q.
// Throughput: one sample per cycle unless record_stall holds back a record.
// Reset: arst_n clears config registers, run state and valid flags at once.
// ----------------------------------------------------------------------------
module smoothed_activity_run_length_encoder_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [sare_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [sare_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [15:0]                   sample,
	input  logic                                 stream_start,
	output logic                                 record_valid,
	input  logic                                 record_stall,
	output logic [1:0]                           record_kind,
	output logic [31:0]                          record_value
);

	sare_pkg::cfg_t  cfg_q;
	sare_pkg::item_t item_s1;
	logic            valid_s1;
	sare_pkg::rec_t  rec;
	sare_pkg::rec_t  rec_q;
	logic            rec_valid_q;
	logic            out_free;
	logic            adv_s1;
	logic            accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sare_pkg::CFG_THRESHOLD: cfg_q.threshold <= cfg_data[sare_pkg::SAMPLE_WIDTH-1:0];
				sare_pkg::CFG_SILENCE_LIMIT: cfg_q.silence_limit <= cfg_data;
				sare_pkg::CFG_SMOOTHING: cfg_q.smoothing <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign out_free = !rec_valid_q || !record_stall;
	assign adv_s1 = valid_s1 && (!rec.emit || out_free);
	assign sample_stall = valid_s1 && !adv_s1;
	assign accept = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.sample <= sample;
			item_s1.stream_start <= stream_start;
		end
	end

	sare_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.rec    (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (adv_s1 && rec.emit) begin
			rec_valid_q <= 1'b1;
		end else if (!record_stall) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rec.emit) begin
			rec_q <= rec;
		end
	end

	assign record_valid = rec_valid_q;
	assign record_kind = rec_q.kind;
	assign record_value = rec_q.value;

endmodule

>>> rtl/sare_step.sv
// ----------------------------------------------------------------------------
// sare_step
// Run state and record decision for one registered sample: level compare,
// run counter, smoothing flags.
// ----------------------------------------------------------------------------
module sare_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  sare_pkg::item_t item,
	input  sare_pkg::cfg_t  cfg,
	output sare_pkg::rec_t  rec
);

	logic                               prev_level_q;
	logic [sare_pkg::COUNT_WIDTH-1:0]   run_count_q;
	logic                               merge_next_q;
	logic                               any_run_q;

	logic [sare_pkg::SAMPLE_WIDTH:0]    mag;
	logic                               level;
	logic                               change;
	logic                               add;
	logic                               short_silence;
	logic [sare_pkg::COUNT_WIDTH-1:0]   count_base;
	logic [sare_pkg::COUNT_WIDTH-1:0]   count_next;
	logic                               merge_next_d;
	logic                               any_run_d;

	always_comb begin
		if (item.sample[sare_pkg::SAMPLE_WIDTH-1]) begin
			mag = -{item.sample[sare_pkg::SAMPLE_WIDTH-1], item.sample};
		end else begin
			mag = {1'b0, item.sample};
		end
		if (cfg.threshold[sare_pkg::SAMPLE_WIDTH-1]) begin
			level = 1'b1;
		end else begin
			level = mag > {1'b0, cfg.threshold};
		end
	end

	assign change = level != prev_level_q;
	assign short_silence = sare_pkg::CMP_WIDTH'(run_count_q)
		<= sare_pkg::CMP_WIDTH'(cfg.silence_limit);

	always_comb begin
		add = 1'b0;
		if (cfg.smoothing) begin
			if (prev_level_q && merge_next_q) begin
				add = 1'b1;
			end else if (!prev_level_q && short_silence && any_run_q) begin
				add = 1'b1;
			end
		end
	end

	always_comb begin
		rec.emit = 1'b0;
		rec.kind = sare_pkg::KIND_START;
		rec.value = '0;
		merge_next_d = merge_next_q;
		any_run_d = any_run_q;
		if (item.stream_start) begin
			rec.emit = 1'b1;
			rec.value = sare_pkg::VALUE_WIDTH'(level);
			merge_next_d = 1'b0;
			any_run_d = 1'b0;
		end else if (change) begin
			rec.emit = 1'b1;
			rec.value = sare_pkg::clip_value(run_count_q);
			if (add) begin
				rec.kind = sare_pkg::KIND_ADD;
				merge_next_d = !merge_next_q;
			end else begin
				rec.kind = sare_pkg::KIND_APPEND;
				any_run_d = 1'b1;
			end
		end
	end

	always_comb begin
		count_base = (item.stream_start || change) ? '0 : run_count_q;
		count_next = (count_base == sare_pkg::COUNT_MAX) ? count_base
			: count_base + sare_pkg::COUNT_WIDTH'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= 1'b0;
			run_count_q <= '0;
			merge_next_q <= 1'b0;
			any_run_q <= 1'b0;
		end else if (en) begin
			prev_level_q <= level;
			run_count_q <= count_next;
			merge_next_q <= merge_next_d;
			any_run_q <= any_run_d;
		end
	end

endmodule

>>> dv/smoothed_activity_run_length_encoder_top_tb.sv
// ----------------------------------------------------------------------------
// smoothed_activity_run_length_encoder_top_tb
// Self-checking bench for the activity run-length encoder. A scoreboard
// predicts each record from every accepted sample beat and checks the record
// stream in order. Stimulus is a short directed part followed by random runs
// of active and silent samples under several register settings, with random
// gaps on both sides, a long record back-pressure and a full drain.
// ----------------------------------------------------------------------------
module smoothed_activity_run_length_encoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_BEATS = 155;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		sare_pkg::record_kind_t           kind;
		logic [sare_pkg::VALUE_WIDTH-1:0] value;
	} run_record_t;

	class run_length_scoreboard;
		logic signed [sare_pkg::SAMPLE_WIDTH-1:0] threshold;
		logic [sare_pkg::LIMIT_WIDTH-1:0]         silence_limit;
		logic                                     smoothing;
		logic                                     prev_level;
		logic [sare_pkg::COUNT_WIDTH-1:0]         run_len;
		logic                                     merge_pending;
		logic                                     run_emitted;
		run_record_t                              pending_records[$];
		int                                       errors;

		function new();
			threshold = '0;
			silence_limit = '0;
			smoothing = 1'b0;
			prev_level = 1'b0;
			run_len = '0;
			merge_pending = 1'b0;
			run_emitted = 1'b0;
			errors = 0;
		endfunction

		function void set_config(logic [sare_pkg::CFG_INDEX_WIDTH-1:0] idx,
				logic [sare_pkg::CFG_DATA_WIDTH-1:0] data);
			case (idx)
				sare_pkg::CFG_THRESHOLD: threshold = data[sare_pkg::SAMPLE_WIDTH-1:0];
				sare_pkg::CFG_SILENCE_LIMIT: silence_limit = data[sare_pkg::LIMIT_WIDTH-1:0];
				sare_pkg::CFG_SMOOTHING: smoothing = data[0];
				default: ;
			endcase
		endfunction

		function void queue_record(run_record_t rec);
			pending_records.insert(pending_records.size(), rec);
		endfunction

		function void note_sample(logic signed [sare_pkg::SAMPLE_WIDTH-1:0] s, logic st);
			int          mag;
			logic        lvl;
			logic        merge;
			run_record_t rec;
			mag = (s < 0) ? -int'(s) : int'(s);
			lvl = mag > int'(threshold);
			if (st) begin
				run_len = '0;
				merge_pending = 1'b0;
				run_emitted = 1'b0;
				rec.kind = sare_pkg::KIND_START;
				rec.value = sare_pkg::VALUE_WIDTH'(lvl);
				queue_record(rec);
			end else if (lvl != prev_level) begin
				merge = 1'b0;
				if (smoothing) begin
					if (prev_level && merge_pending)
						merge = 1'b1;
					else if (!prev_level && run_len <= silence_limit && run_emitted)
						merge = 1'b1;
				end
				if (merge) begin
					merge_pending = !merge_pending;
					rec.kind = sare_pkg::KIND_ADD;
				end else begin
					run_emitted = 1'b1;
					rec.kind = sare_pkg::KIND_APPEND;
				end
				rec.value = (64'(run_len) > 64'hFFFF_FFFF) ? '1
					: sare_pkg::VALUE_WIDTH'(run_len);
				queue_record(rec);
				run_len = '0;
			end
			if (run_len != sare_pkg::COUNT_MAX)
				run_len++;
			prev_level = lvl;
		endfunction

		task report(string msg);
			$display("[%0t] mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_record(logic [1:0] kind, logic [sare_pkg::VALUE_WIDTH-1:0] value);
			run_record_t exp;
			if (pending_records.size() == 0) begin
				report($sformatf("unexpected record kind %0d value %0d", kind, value));
			end else begin
				exp = pending_records.pop_front();
				if (kind !== exp.kind)
					report($sformatf("kind %0d, want %s", kind, exp.kind.name()));
				if (value !== exp.value)
					report($sformatf("value %0d, want %0d (%s)", value, exp.value,
						exp.kind.name()));
			end
		endtask

		task check_drained();
			if (pending_records.size() != 0)
				report($sformatf("%0d records never arrived", pending_records.size()));
		endtask
	endclass

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [sare_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = sare_pkg::CFG_THRESHOLD;
	logic [sare_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic                                 sample_valid = 1'b0;
	logic                                 sample_stall;
	logic signed [15:0]                   sample = '0;
	logic                                 stream_start = 1'b0;
	logic                                 record_valid;
	logic                                 record_stall = 1'b0;
	logic [1:0]                           record_kind;
	logic [31:0]                          record_value;

	run_length_scoreboard sb;
	bit calm = 1'b0;
	bit hold_req = 1'b0;
	int cycle_count = 0;

	smoothed_activity_run_length_encoder_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.stream_start (stream_start),
		.record_valid (record_valid),
		.record_stall (record_stall),
		.record_kind  (record_kind),
		.record_value (record_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("smoothed_activity_run_length_encoder_top regression: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && record_valid && !record_stall)
			sb.check_record(record_kind, record_value);
	end

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				record_stall <= 1'b1;
				hold_left--;
			end else begin
				record_stall <= !calm && ($urandom_range(99) < 15);
			end
		end
	end

	task send_beat(input logic signed [15:0] s, input logic st);
		while (!calm && $urandom_range(99) < 15) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		stream_start <= st;
		do
			@(posedge clk);
		while (sample_stall);
		sb.note_sample(s, st);
		@(negedge clk);
	endtask

	task write_reg(input logic [sare_pkg::CFG_INDEX_WIDTH-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.set_config(idx, data);
		@(negedge clk);
	endtask

	task settle();
		sample_valid <= 1'b0;
		while (sb.pending_records.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
	endtask

	task configure(input int thr, input logic [31:0] limit, input logic smooth);
		settle();
		write_reg(sare_pkg::CFG_THRESHOLD, 32'(thr));
		write_reg(sare_pkg::CFG_SILENCE_LIMIT, limit);
		write_reg(sare_pkg::CFG_SMOOTHING, 32'(smooth));
		cfg_valid <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample(logic active);
		int t;
		int m;
		t = int'(sb.threshold);
		if (t < 0)
			return 16'($urandom);
		if (active) begin
			m = $urandom_range(32768, t + 1);
			if (m == 32768)
				return -16'sd32768;
		end else begin
			m = $urandom_range(t, 0);
		end
		return 16'($urandom_range(1) ? -m : m);
	endfunction

	task run_phase(input int beats, input bit with_hold);
		int   sent;
		int   len;
		logic lvl;
		logic st;
		logic signed [15:0] s;
		sent = 0;
		lvl = $urandom_range(1);
		while (sent < beats) begin
			len = ($urandom_range(99) < 10) ? $urandom_range(40, 7) : $urandom_range(6, 1);
			for (int k = 0; k < len && sent < beats; k++) begin
				if (with_hold && sent == 20)
					hold_req = 1'b1;
				st = ($urandom_range(99) < 2);
				s = ($urandom_range(99) < 5) ? 16'($urandom) : pick_sample(lvl);
				send_beat(s, st);
				sent++;
			end
			lvl = !lvl;
		end
	endtask

	initial begin
		sb = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_beat(16'sd0, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(16'sd5, 1'b0);
		send_beat(-16'sd32768, 1'b1);
		send_beat(16'sd32767, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(-16'sd1, 1'b0);

		configure(10, 32'd2, 1'b1);
		send_beat(16'sd20, 1'b1);
		send_beat(16'sd20, 1'b0);
		send_beat(-16'sd20, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(16'sd10, 1'b0);
		send_beat(-16'sd11, 1'b0);
		send_beat(16'sd11, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(16'sd3, 1'b0);
		send_beat(16'sd0, 1'b0);
		send_beat(-16'sd10, 1'b0);
		send_beat(16'sd12, 1'b0);
		send_beat(16'sd0, 1'b1);
		send_beat(16'sd11, 1'b0);

		configure(32767, 32'd0, 1'b0);
		send_beat(-16'sd32768, 1'b1);
		send_beat(16'sd32767, 1'b0);
		send_beat(-16'sd32767, 1'b0);
		send_beat(-16'sd32768, 1'b0);

		configure(0, 32'd0, 1'b0);
		run_phase(PHASE_BEATS, 1'b0);
		configure(1000, 32'd3, 1'b1);
		run_phase(PHASE_BEATS, 1'b0);
		configure(-32768, 32'hFFFF_FFFF, 1'b1);
		run_phase(PHASE_BEATS, 1'b0);
		configure(300, 32'hFFFF_FFFF, 1'b1);
		run_phase(PHASE_BEATS, 1'b0);
		configure(32767, 32'd0, 1'b1);
		run_phase(PHASE_BEATS, 1'b0);
		configure(6000, 32'd1, 1'b1);
		calm = 1'b1;
		run_phase(PHASE_BEATS, 1'b1);
		calm = 1'b0;
		configure(100, 32'd6, 1'b0);
		run_phase(PHASE_BEATS, 1'b0);
		configure(20000, 32'd4, 1'b1);
		run_phase(PHASE_BEATS, 1'b0);

		sample_valid <= 1'b0;
		while (sb.pending_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("smoothed_activity_run_length_encoder_top regression: pass");
		else
			$display("smoothed_activity_run_length_encoder_top regression: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/sare_pkg.sv
rtl/sare_step.sv
rtl/smoothed_activity_run_length_encoder_top.sv
dv/smoothed_activity_run_length_encoder_top_tb.sv
